// ----- rtl/plm_pkg.sv -----
package plm_pkg;

    // Default number of palette entries
    localparam int PALETTE_DEPTH_DEF = 16;

    // Field widths
    localparam int CHAN_W  = 16;
    localparam int VALUE_W = 18;
    localparam int FRAC_W  = 16;
    localparam int INDEX_W = 4;
    localparam int CFG_W   = 5;
    localparam int ENTRY_W = 3 * CHAN_W;

    // Stream packing
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    // APB
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Word kinds carried in tuser
    localparam logic FUNC_MAP   = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Register word index
    localparam logic REG_PALETTE_SIZE = 1'b0;

endpackage

// ----- rtl/plm_blend.sv -----
module plm_blend
    import plm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_black,
    input  logic [CHAN_W-1:0] i_c0,
    input  logic [CHAN_W-1:0] i_c1,
    input  logic [FRAC_W-1:0] i_frac,
    output logic [CHAN_W-1:0] o_chan
);

    localparam int DIFF_W = CHAN_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;
    localparam int SUM_W  = CHAN_W + 2;

    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [FRAC_W:0]     w_frac_s;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   r_prod;
    logic        [CHAN_W-1:0]   r_c0;
    logic        [SUM_W-1:0]    w_sum;
    logic        [CHAN_W-1:0]   r_chan;

    // c0 + floor((c1 - c0) * f / 2^16) equals the two-term blend
    assign w_diff   = $signed({1'b0, i_c1}) - $signed({1'b0, i_c0});
    assign w_frac_s = $signed({1'b0, i_frac});
    assign w_prod   = w_diff * w_frac_s;

    // Stage: product, forced to zero for an empty palette
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_black ? '0 : w_prod;
            r_c0   <= i_black ? '0 : i_c0;
        end
    end

    // Stage: add the floored product back onto the base colour
    assign w_sum = {2'b00, r_c0} + SUM_W'(r_prod >>> FRAC_W);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan <= w_sum[CHAN_W-1:0];
        end
    end

    assign o_chan = r_chan;

endmodule

// ----- rtl/palette_linear_interpolation.sv -----
// Channel    | Dir | Handshake            | Contents
// -----------+-----+----------------------+------------------------------------------
// s_axis     | in  | tvalid/tready        | one map or palette-write word per beat
// m_axis     | out | tvalid/tready        | one colour per map word
// APB        | in  | psel/penable/pready  | palette_size at byte address 0
//
// One word is taken every cycle while the output is not stalled; each map word
// yields one colour. Stages: clamp and scale multiply, palette RAM read (registered),
// blend multiply, blend add into the output register. Palette writes land at the RAM stage, so a
// map word right behind a write sees the new entry. Reset clears the valid bits and
// palette_size only; the palette RAM has no reset and needs no clearing pass.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module palette_linear_interpolation
    import plm_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // value[17:0], entry_index[21:18], entry_red[37:22], entry_green[53:38],
    // entry_blue[69:54], zero[71:70]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // func[0]
    input  logic [0:0]           s_axis_tuser,
    // master stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // red[15:0], green[31:16], blue[47:32]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int IW   = $clog2(PALETTE_DEPTH);
    localparam int NW   = $clog2(PALETTE_DEPTH + 1);
    localparam int CW   = (NW > CFG_W) ? NW : CFG_W;
    localparam int XW   = (IW > INDEX_W) ? IW : INDEX_W;
    localparam int PW   = FRAC_W + IW;

    localparam logic [1:0] SEL_BLACK = 2'd0;
    localparam logic [1:0] SEL_LOW   = 2'd1;
    localparam logic [1:0] SEL_HIGH  = 2'd2;
    localparam logic [1:0] SEL_MID   = 2'd3;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_size;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & (paddr[2] == REG_PALETTE_SIZE);
    assign prdata   = (paddr[2] == REG_PALETTE_SIZE) ? APB_DW'(r_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (w_cfg_wr) begin
            r_size <= pwdata[CFG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable: freeze everything while the output word waits
    // ------------------------------------------------------------------
    logic w_en;
    logic r_out_valid;

    assign w_en          = ~r_out_valid | m_axis_tready;
    assign s_axis_tready = w_en;

    // ------------------------------------------------------------------
    // Stage A: unpack, clamp and scale
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] w_value;
    logic [INDEX_W-1:0]        w_index;
    logic [XW-1:0]             w_index_x;
    logic [ENTRY_W-1:0]        w_entry;
    logic [CW-1:0]             w_size_x;
    logic [CW-1:0]             w_n_x;
    logic [NW-1:0]             w_n;
    logic [NW-1:0]             w_n_m1;
    logic [IW-1:0]             w_nm1;
    logic [1:0]                w_sel;
    logic [PW-1:0]             w_scaled;

    assign w_value   = s_axis_tdata[VALUE_W-1:0];
    assign w_index   = s_axis_tdata[VALUE_W +: INDEX_W];
    assign w_index_x = XW'(w_index);
    assign w_entry   = s_axis_tdata[VALUE_W + INDEX_W +: ENTRY_W];

    // Saturate palette_size at the depth
    assign w_size_x = CW'(r_size);
    assign w_n_x    = (w_size_x > CW'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH) : w_size_x;
    assign w_n      = w_n_x[NW-1:0];
    assign w_n_m1   = w_n - NW'(1);
    assign w_nm1    = w_n_m1[IW-1:0];

    assign w_scaled = PW'(w_value[FRAC_W-1:0]) * PW'(w_nm1);

    always_comb begin
        if (w_n == '0) begin
            w_sel = SEL_BLACK;
        end else if (w_n == NW'(1) || w_value[VALUE_W-1] || w_value == '0) begin
            w_sel = SEL_LOW;
        end else if (w_value[FRAC_W]) begin
            w_sel = SEL_HIGH;
        end else begin
            w_sel = SEL_MID;
        end
    end

    logic               r_a_valid;
    logic               r_a_map;
    logic               r_a_wok;
    logic [1:0]         r_a_sel;
    logic [PW-1:0]      r_a_scaled;
    logic [IW-1:0]      r_a_nm1;
    logic [IW-1:0]      r_a_waddr;
    logic [ENTRY_W-1:0] r_a_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_map    <= (s_axis_tuser[0] == FUNC_MAP);
            r_a_wok    <= (int'(w_index) < PALETTE_DEPTH);
            r_a_sel    <= w_sel;
            r_a_scaled <= w_scaled;
            r_a_nm1    <= w_nm1;
            r_a_waddr  <= w_index_x[IW-1:0];
            r_a_entry  <= w_entry;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: pick neighbours, write or read the palette RAM
    // ------------------------------------------------------------------
    logic [IW-1:0]     w_lo;
    logic [IW-1:0]     w_hi;
    logic [FRAC_W-1:0] w_frac;

    always_comb begin
        case (r_a_sel)
            SEL_HIGH: begin
                w_lo   = r_a_nm1;
                w_hi   = r_a_nm1;
                w_frac = '0;
            end
            SEL_MID: begin
                w_lo   = r_a_scaled[PW-1:FRAC_W];
                w_hi   = r_a_scaled[PW-1:FRAC_W] + IW'(1);
                w_frac = r_a_scaled[FRAC_W-1:0];
            end
            default: begin
                w_lo   = '0;
                w_hi   = '0;
                w_frac = '0;
            end
        endcase
    end

    logic [ENTRY_W-1:0] r_mem [PALETTE_DEPTH];
    logic [ENTRY_W-1:0] r_b_c0;
    logic [ENTRY_W-1:0] r_b_c1;
    logic [FRAC_W-1:0]  r_b_frac;
    logic               r_b_black;
    logic               r_b_valid;

    // Store a palette word as it passes
    always_ff @(posedge i_clk) begin
        if (w_en && r_a_valid && !r_a_map && r_a_wok) begin
            r_mem[r_a_waddr] <= r_a_entry;
        end
    end

    // Read both neighbours
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_c0    <= r_mem[w_lo];
            r_b_c1    <= r_mem[w_hi];
            r_b_frac  <= w_frac;
            r_b_black <= (r_a_sel == SEL_BLACK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid & r_a_map;
        end
    end

    // ------------------------------------------------------------------
    // Stages C and D: per-channel blend
    // ------------------------------------------------------------------
    logic r_c_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_chan
        plm_blend u_blend (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_black (r_b_black),
            .i_c0    (r_b_c0[g*CHAN_W +: CHAN_W]),
            .i_c1    (r_b_c1[g*CHAN_W +: CHAN_W]),
            .i_frac  (r_b_frac),
            .o_chan  (m_axis_tdata[g*CHAN_W +: CHAN_W])
        );
    end

    assign m_axis_tvalid = r_out_valid;

endmodule
